/* hdl/text_console_writer_top_assert.svh */
// ---------------------------------------------------------------------------
// text_console_writer_top_assert.svh
// Assertion macros for the console writer RTL.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCW_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tcw_pkg.sv */
// ---------------------------------------------------------------------------
// tcw_pkg
// Types, codes and constants of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int ACTION_W = 3;
    localparam int GLYPH_W  = 8;
    localparam int COLOR_W  = 4;
    localparam int STEP_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CELL_W   = 16;

    localparam logic [GLYPH_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [GLYPH_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [COLOR_W-1:0] BLANK_FORE   = 4'd7;
    localparam logic [COLOR_W-1:0] BLANK_BACK   = 4'd0;
    localparam logic [CELL_W-1:0]  BLANK_CELL   = {BLANK_BACK, BLANK_FORE, SPACE_CHAR};

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 3'd0,
        ACT_PUT   = 3'd1,
        ACT_LEFT  = 3'd2,
        ACT_RIGHT = 3'd3,
        ACT_READ  = 3'd4
    } tcw_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCROLL,
        ST_NORM,
        ST_READ,
        ST_DONE
    } tcw_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [GLYPH_W-1:0]  glyph;
        logic [COLOR_W-1:0]  fore_color;
        logic [COLOR_W-1:0]  back_color;
        logic [STEP_W-1:0]   step_count;
        logic [IDX_W-1:0]    cell_index;
    } tcw_cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
    } tcw_rsp_t;

endpackage

/* hdl/tcw_stream_if.sv */
// ---------------------------------------------------------------------------
// tcw_stream_if
// Valid/ready channel carrying one word of the given payload type.
// ---------------------------------------------------------------------------
interface tcw_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/tcw_ram.sv */
// ---------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* hdl/text_console_writer_top.sv */
// Flow: an accepted word goes to the done state, which posts the answer once rsp is
// free; an in-range read passes a RAM read state and an unsaturated left/right a column-fix state first.
// Clear sweeps the screen RAM, one RAM write per cycle; a put that wraps scrolls
// the screen up a row first. One word at a time; cmd.ready is high only when idle.
// Reset: cursor homed, then a clearing pass blanks the screen RAM with cmd.ready
// low and posts no response.
// ---------------------------------------------------------------------------
// text_console_writer_top
// Text-mode screen store with cursor, put/newline/scroll, clear, moves and reads.
// ---------------------------------------------------------------------------
`include "text_console_writer_top_assert.svh"

module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic          clk,
    input  logic          rst_n,
    tcw_stream_if.sink    cmd,
    tcw_stream_if.source  rsp
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int PW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + 1);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int AW    = ((PW > IDX_W) ? PW : IDX_W) + 1;
    localparam int TW    = ((CLW > STEP_W) ? CLW : STEP_W) + 2;
    localparam logic [AW-1:0] CellsExt = AW'(CELLS);

    tcw_state_t      state_reg, state_next;
    logic [SW-1:0]   sweep_reg, sweep_next;
    logic            report_reg, report_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [CLW-1:0]  col_reg, col_next;
    logic [TW-1:0]   t_reg, t_next;
    logic [CELL_W-1:0] value_reg, value_next;
    logic            rsp_valid_reg, rsp_valid_next;
    tcw_rsp_t        rsp_word_reg, rsp_word_next;

    logic              wr_en, rd_en;
    logic [PW-1:0]     wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data, rd_data;

    logic          accept, is_newline, put_wrap, left_sat, right_sat, read_ok;
    logic          t_neg, t_hi, norm_done, sweep_last, scroll_last, out_free;
    logic [AW-1:0] pos_ext, count_ext, put_pos, right_sum;
    logic [SW:0]   scroll_src;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept     = cmd.valid && cmd.ready;
    assign is_newline = cmd.payload.glyph == NEWLINE_CHAR;
    assign pos_ext    = AW'(pos_reg);
    assign count_ext  = AW'(cmd.payload.step_count);
    assign put_pos    = is_newline ? (pos_ext - AW'(col_reg) + AW'(COLUMNS))
                                   : (pos_ext + AW'(1));
    assign put_wrap   = put_pos >= CellsExt;
    assign left_sat   = pos_ext < count_ext;
    assign right_sum  = pos_ext + count_ext;
    assign right_sat  = right_sum > (CellsExt - AW'(1));
    assign read_ok    = AW'(cmd.payload.cell_index) < CellsExt;
    assign t_neg      = t_reg[TW-1];
    assign t_hi       = !t_neg && (t_reg >= TW'(COLUMNS));
    assign norm_done  = !t_neg && !t_hi;
    assign sweep_last = sweep_reg == SW'(CELLS - 1);
    assign scroll_last = sweep_reg == SW'(CELLS);
    assign scroll_src = (SW + 1)'(sweep_reg) + (SW + 1)'(COLUMNS);
    assign out_free   = !rsp_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.payload.action)
                        ACT_CLEAR: state_next = ST_SWEEP;
                        ACT_PUT:   state_next = put_wrap ? ST_SCROLL : ST_DONE;
                        ACT_LEFT:  state_next = left_sat ? ST_DONE : ST_NORM;
                        ACT_RIGHT: state_next = right_sat ? ST_DONE : ST_NORM;
                        ACT_READ:  state_next = read_ok ? ST_READ : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                if (scroll_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_NORM:
            begin
                if (norm_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, RAM control and outputs
    always_comb
    begin
        sweep_next     = sweep_reg;
        report_next    = report_reg;
        pos_next       = pos_reg;
        col_next       = col_reg;
        t_next         = t_reg;
        value_next     = value_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_word_next  = rsp_word_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = BLANK_CELL;
        rd_en          = 1'b0;
        rd_addr        = PW'(cmd.payload.cell_index);
        cmd.ready      = state_reg == ST_IDLE;
        rsp.valid      = rsp_valid_reg;
        rsp.payload    = rsp_word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next = '0;
                    sweep_next = '0;
                    case (cmd.payload.action)
                        ACT_CLEAR:
                        begin
                            pos_next    = '0;
                            col_next    = '0;
                            report_next = 1'b1;
                        end
                        ACT_PUT:
                        begin
                            if (!is_newline)
                            begin
                                wr_en    = 1'b1;
                                wr_data  = {cmd.payload.back_color, cmd.payload.fore_color,
                                            cmd.payload.glyph};
                                col_next = (col_reg == CLW'(COLUMNS - 1)) ? '0
                                                                          : col_reg + CLW'(1);
                            end
                            else
                            begin
                                col_next = '0;
                            end
                            pos_next = put_wrap ? PW'(put_pos - AW'(COLUMNS)) : PW'(put_pos);
                        end
                        ACT_LEFT:
                        begin
                            if (left_sat)
                            begin
                                pos_next = '0;
                                col_next = '0;
                            end
                            else
                            begin
                                pos_next = PW'(pos_ext - count_ext);
                                t_next   = TW'(col_reg) - TW'(cmd.payload.step_count);
                            end
                        end
                        ACT_RIGHT:
                        begin
                            if (right_sat)
                            begin
                                pos_next = PW'(CELLS - 1);
                                col_next = CLW'(COLUMNS - 1);
                            end
                            else
                            begin
                                pos_next = PW'(right_sum);
                                t_next   = TW'(col_reg) + TW'(cmd.payload.step_count);
                            end
                        end
                        ACT_READ:
                        begin
                            rd_en = read_ok;
                        end
                        default:
                        begin
                            value_next = '0;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg[PW-1:0];
                sweep_next = sweep_reg + SW'(1);
            end
            ST_SCROLL:
            begin
                // read row below at s, write back at s-1; bottom row blanked
                rd_en   = scroll_src < (SW + 1)'(CELLS);
                rd_addr = scroll_src[PW-1:0];
                wr_en   = sweep_reg != '0;
                wr_addr = PW'(sweep_reg - SW'(1));
                wr_data = (sweep_reg <= SW'(CELLS - COLUMNS)) ? rd_data : BLANK_CELL;
                sweep_next = sweep_reg + SW'(1);
            end
            ST_NORM:
            begin
                if (t_neg)
                begin
                    t_next = t_reg + TW'(COLUMNS);
                end
                else if (t_hi)
                begin
                    t_next = t_reg - TW'(COLUMNS);
                end
                else
                begin
                    col_next = CLW'(t_reg);
                end
            end
            ST_READ:
            begin
                value_next = rd_data;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next                = 1'b1;
                    rsp_word_next.cursor_position = IDX_W'(pos_reg);
                    rsp_word_next.cell_value      = value_reg;
                end
            end
            default:
            begin
                report_next = report_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            report_reg    <= 1'b0;
            pos_reg       <= '0;
            col_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            report_reg    <= report_next;
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        value_reg    <= value_next;
        rsp_word_reg <= rsp_word_next;
    end

    `TCW_ASSERT_HOLDS(a_pos_in_range, state_reg == ST_IDLE, AW'(pos_reg) < CellsExt,
        "cursor position beyond screen")
    `TCW_ASSERT_HOLDS(a_col_in_range, state_reg == ST_IDLE, (CLW + 1)'(col_reg) < (CLW + 1)'(COLUMNS),
        "cursor column beyond row")
    `TCW_ASSERT_HOLDS(a_wr_in_range, wr_en, AW'(wr_addr) < CellsExt,
        "screen RAM write out of range")
    `TCW_ASSERT_HOLDS(a_scroll_no_overlap, state_reg == ST_SCROLL && wr_en && rd_en, wr_addr != rd_addr,
        "scroll read and write hit the same cell")
    `TCW_ASSERT_NEXT(a_done_posts, state_reg == ST_DONE && out_free, rsp.valid && state_reg == ST_IDLE,
        "finished word not posted")
endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Checks the text console writer against a cycle-free model of its screen
// store and cursor. Directed words cover reads, puts, newline, moves with
// saturation, scrolling, unknown actions and clear. Random traffic then runs
// under several idle/stall mixes. Each response word is compared field by
// field with the oldest predicted word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam int SCREEN_COLUMNS = DEF_COLUMNS;
    localparam int SCREEN_ROWS    = DEF_ROWS;
    localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int MAX_REPORTS    = 10;

    // action codes the block ignores
    localparam logic [ACTION_W-1:0] ACT_BAD_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_BAD_HI = 3'd7;

    logic clk;
    logic rst_n;

    tcw_stream_if #(.payload_t(tcw_cmd_t)) cmd_if ();
    tcw_stream_if #(.payload_t(tcw_rsp_t)) rsp_if ();

    text_console_writer_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source)
    );

    // console model
    logic [CELL_W-1:0] screen_mem [SCREEN_CELLS];
    int                cur_row;
    int                cur_col;

    tcw_rsp_t expected_rsp_q [$];
    int       mismatch_count;
    int       send_idle_pct;
    int       recv_stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void blank_screen();
        for (int i = 0; i < SCREEN_CELLS; i++)
        begin
            screen_mem[i] = BLANK_CELL;
        end
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < SCREEN_CELLS - SCREEN_COLUMNS; i++)
        begin
            screen_mem[i] = screen_mem[i + SCREEN_COLUMNS];
        end
        for (int i = SCREEN_CELLS - SCREEN_COLUMNS; i < SCREEN_CELLS; i++)
        begin
            screen_mem[i] = BLANK_CELL;
        end
    endfunction

    function automatic int cursor_linear();
        return cur_row * SCREEN_COLUMNS + cur_col;
    endfunction

    function automatic void set_cursor(int pos);
        cur_row = pos / SCREEN_COLUMNS;
        cur_col = pos % SCREEN_COLUMNS;
    endfunction

    function automatic tcw_rsp_t console_apply(tcw_cmd_t c);
        tcw_rsp_t r;
        int       pos;
        r.cell_value = '0;
        case (c.action)
            ACT_CLEAR:
            begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            ACT_PUT:
            begin
                if (c.glyph == NEWLINE_CHAR)
                begin
                    cur_row++;
                    cur_col = 0;
                end
                else
                begin
                    screen_mem[cursor_linear()] = {c.back_color, c.fore_color, c.glyph};
                    cur_col++;
                    if (cur_col >= SCREEN_COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                if (cur_row >= SCREEN_ROWS)
                begin
                    cur_row = SCREEN_ROWS - 1;
                    scroll_screen();
                end
            end
            ACT_LEFT:
            begin
                pos = cursor_linear();
                set_cursor(pos >= int'(c.step_count) ? pos - int'(c.step_count) : 0);
            end
            ACT_RIGHT:
            begin
                pos = cursor_linear() + int'(c.step_count);
                if (pos > SCREEN_CELLS - 1)
                begin
                    pos = SCREEN_CELLS - 1;
                end
                set_cursor(pos);
            end
            ACT_READ:
            begin
                if (int'(c.cell_index) < SCREEN_CELLS)
                begin
                    r.cell_value = screen_mem[c.cell_index];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_position = IDX_W'(cursor_linear());
        return r;
    endfunction

    function automatic tcw_cmd_t make_word(logic [ACTION_W-1:0] act, int glyph, int fore,
                                           int back, int step, int index);
        tcw_cmd_t c;
        c.action     = act;
        c.glyph      = GLYPH_W'(glyph);
        c.fore_color = COLOR_W'(fore);
        c.back_color = COLOR_W'(back);
        c.step_count = STEP_W'(step);
        c.cell_index = IDX_W'(index);
        return c;
    endfunction

    task automatic send_word(tcw_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        expected_rsp_q.push_back(console_apply(c));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic report_mismatch(string field, int want, int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t mismatch %s: expected %0d (0x%0h) got %0d (0x%0h)",
                     $realtime, field, want, want, got, got);
        end
    endtask

    // response checker
    always @(posedge clk)
    begin : check_rsp
        tcw_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                report_mismatch("unexpected word", 0, int'(rsp_if.payload));
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.payload.cursor_position !== want.cursor_position)
                begin
                    report_mismatch("cursor_position", int'(want.cursor_position),
                                    int'(rsp_if.payload.cursor_position));
                end
                if (rsp_if.payload.cell_value !== want.cell_value)
                begin
                    report_mismatch("cell_value", int'(want.cell_value),
                                    int'(rsp_if.payload.cell_value));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_contents();
        send_word(make_word(ACT_READ, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_READ, 0, 0, 0, 0, SCREEN_CELLS - 1));
        send_word(make_word(ACT_READ, 0, 0, 0, 0, SCREEN_CELLS));
    endtask

    task automatic test_put_newline();
        send_word(make_word(ACT_PUT, 255, 15, 15, 0, 0));
        send_word(make_word(ACT_PUT, NEWLINE_CHAR, 9, 3, 0, 0));
        send_word(make_word(ACT_PUT, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_PUT, 8'h41, 10, 5, 0, 0));
    endtask

    task automatic test_cursor_moves();
        send_word(make_word(ACT_LEFT, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_LEFT, 0, 0, 0, 255, 0));
        // walk to the last cell and saturate there
        repeat (8)
        begin
            send_word(make_word(ACT_RIGHT, 0, 0, 0, 255, 0));
        end
    endtask

    task automatic test_scroll();
        send_word(make_word(ACT_PUT, 8'h7E, 12, 2, 0, 0));
        send_word(make_word(ACT_READ, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_READ, 0, 0, 0, 0, SCREEN_CELLS - SCREEN_COLUMNS - 1));
        send_word(make_word(ACT_PUT, NEWLINE_CHAR, 15, 15, 0, 0));
    endtask

    task automatic test_unknown_and_clear();
        int a;
        for (a = ACT_BAD_LO; a <= ACT_BAD_HI; a++)
        begin
            send_word(make_word(ACTION_W'(a), 255, 15, 15, 255, 2047));
        end
        send_word(make_word(ACT_CLEAR, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_READ, 0, 0, 0, 0, 0));
    endtask

    function automatic tcw_cmd_t random_word();
        tcw_cmd_t c;
        int       pick;
        int       pos;
        c = make_word(ACT_PUT, $urandom_range(255), $urandom_range(15),
                      $urandom_range(15), $urandom_range(255), $urandom_range(2047));
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            c.action = ACT_PUT;
            if ($urandom_range(99) < 12)
            begin
                c.glyph = NEWLINE_CHAR;
            end
        end
        else if (pick < 62)
        begin
            c.action = ACT_LEFT;
        end
        else if (pick < 74)
        begin
            c.action = ACT_RIGHT;
        end
        else if (pick < 92)
        begin
            c.action = ACT_READ;
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // just behind the cursor, where text was written
                pos = cursor_linear() - int'($urandom_range(160, 1));
                c.cell_index = IDX_W'(pos < 0 ? 0 : pos);
            end
            else if (pick < 85)
            begin
                c.cell_index = IDX_W'($urandom_range(SCREEN_CELLS - 1));
            end
            else
            begin
                c.cell_index = IDX_W'($urandom_range(2047, SCREEN_CELLS));
            end
        end
        else if (pick < 94)
        begin
            c.action = ACT_CLEAR;
        end
        else
        begin
            c.action = ACTION_W'($urandom_range(ACT_BAD_HI, ACT_BAD_LO));
        end
        if ((c.action == ACT_LEFT || c.action == ACT_RIGHT) && $urandom_range(1) == 0)
        begin
            c.step_count = STEP_W'($urandom_range(15));
        end
        return c;
    endfunction

    task automatic test_random_traffic(int n_words, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_words)
        begin
            send_word(random_word());
        end
        // hold off until every outstanding word has come back
        wait_drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        rsp_if.ready   = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        blank_screen();
        cur_row = 0;
        cur_col = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_put_newline();
        test_cursor_moves();
        test_scroll();
        test_unknown_and_clear();
        wait_drain();

        test_random_traffic(75, 0, 0);
        test_random_traffic(75, 56, 0);
        test_random_traffic(75, 0, 56);
        test_random_traffic(75, 13, 13);

        wait_drain();
        repeat (20) @(posedge clk);
        mismatch_count += expected_rsp_q.size();
        if (mismatch_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
